[rtl/skse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skse_pkg: shared types and constants of the knot slope estimator
// Default widths, slope reason codes, controller states and the status word
// that the serial divider hands back to the controller.
// ----------------------------------------------------------------------------
package skse_pkg;

   // Default coordinate format: signed Q16.16
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int REASON_WIDTH    = 3;

   // Why a slope has the value it has
   typedef enum logic [REASON_WIDTH-1:0] {
      REASON_COMPUTED  = 3'd0,
      REASON_EQUAL_X   = 3'd1,
      REASON_EXTREMUM  = 3'd2,
      REASON_LONE      = 3'd3,
      REASON_SATURATED = 3'd4
   } reason_type;

   // Number of knots held in the window
   typedef enum logic [1:0] {
      HELD_NONE = 2'd0,
      HELD_ONE  = 2'd1,
      HELD_TWO  = 2'd2
   } held_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIFF,
      ST_ABS,
      ST_DIV,
      ST_EMIT
   } state_type;

   // Divider status back to the controller
   typedef struct packed {
      logic done;
      logic sat;
   } div_status_type;

endpackage

[rtl/skse_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skse_divider: bit-serial saturating fixed-point divider
// Computes (num << FRAC_BITS) / den on magnitudes, one quotient bit per
// cycle, then saturates to the signed range and applies the sign.
// ----------------------------------------------------------------------------
module skse_divider #(
   parameter int COORD_WIDTH = skse_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = skse_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [COORD_WIDTH-1:0]       num,
   input  logic [COORD_WIDTH-1:0]       den,
   input  logic                         neg,
   output logic [COORD_WIDTH-1:0]       slope,
   output skse_pkg::div_status_type     status
);
   import skse_pkg::*;

   localparam int W     = COORD_WIDTH;
   localparam int Steps = COORD_WIDTH + FRAC_BITS;
   localparam int CntW  = $clog2(Steps + 1);

   logic            busy_ff, busy_in;
   logic            fix_ff, fix_in;
   logic            done_ff, done_in;
   logic            sat_ff, sat_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]    num_ff, num_in;
   logic [W-1:0]    den_ff, den_in;
   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    quo_ff, quo_in;
   logic            ovf_ff, ovf_in;
   logic            neg_ff, neg_in;
   logic [W-1:0]    slope_ff, slope_in;

   logic [W:0]      trial;
   logic [W:0]      trial_sub;
   logic            trial_ge;
   logic            q_over;
   logic            sat_now;
   logic [W-1:0]    mag;

   // Shift the next dividend bit into the partial remainder and try a subtract
   assign trial     = {rem_ff, num_ff[W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign trial_ge  = (trial >= {1'b0, den_ff});

   // Clamp to the signed range, then apply the sign
   assign q_over  = quo_ff[W-1] & (~neg_ff | (|quo_ff[W-2:0]));
   assign sat_now = ovf_ff | q_over;
   assign mag     = sat_now ? (neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                            : quo_ff;

   // Next values
   always_comb begin
      busy_in  = busy_ff;
      fix_in   = 1'b0;
      done_in  = 1'b0;
      sat_in   = sat_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ovf_in   = ovf_ff;
      neg_in   = neg_ff;
      slope_in = slope_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(Steps);
         num_in  = num;
         den_in  = den;
         neg_in  = neg;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[W-2:0], 1'b0};
         rem_in = trial_ge ? trial_sub[W-1:0] : trial[W-1:0];
         quo_in = {quo_ff[W-2:0], trial_ge};
         ovf_in = ovf_ff | quo_ff[W-1];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end
      if (fix_ff) begin
         slope_in = neg_ff ? (~mag + 1'b1) : mag;
         sat_in   = sat_now;
         done_in  = 1'b1;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      sat_ff   <= sat_in;
      cnt_ff   <= cnt_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      ovf_ff   <= ovf_in;
      neg_ff   <= neg_in;
      slope_ff <= slope_in;
   end

   assign slope       = slope_ff;
   assign status.done = done_ff;
   assign status.sat  = sat_ff;

endmodule

[rtl/spline_knot_slope_estimator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spline_knot_slope_estimator: monotone Hermite tangents for spline knots
// Keeps a two-knot window and emits each knot's tangent once its right
// neighbour has arrived; the final knot of a curve gets its slope too.
// ----------------------------------------------------------------------------
// One knot is taken at a time. A knot that needs no division (first knot of a
// curve, equal abscissas, extremum or plateau) skips the divider. Each chord
// slope with a nonzero x difference goes through the bit-serial divider, which
// retires one quotient bit per cycle; a final knot that arrives with two knots
// held can need two chords. A finished word waits in the output register, and
// the next knot is taken while it waits. Quotients (Q16.16 by default) truncate
// toward zero and saturate with a reason code of saturated.
module spline_knot_slope_estimator #(
   parameter int COORD_WIDTH = skse_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = skse_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // knot_x, knot_y, zero pad
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,
   input  logic                                     req_tlast,   // final_knot
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // slope, zero pad
   output logic [((COORD_WIDTH+7)/8)*8-1:0]         rsp_tdata,
   // slope_reason, for_final_knot
   output logic [skse_pkg::REASON_WIDTH:0]          rsp_tuser,
   output logic                                     rsp_tlast,   // run_end
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready
);
   import skse_pkg::*;

   localparam int W        = COORD_WIDTH;
   localparam int OutDataW = ((COORD_WIDTH + 7) / 8) * 8;

   state_type      state_ff, state_in;
   held_type       held_ff, held_in;
   logic [W-1:0]   older_x_ff, older_x_in, older_y_ff, older_y_in;
   logic [W-1:0]   newer_x_ff, newer_x_in, newer_y_ff, newer_y_in;
   logic [W-1:0]   cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic           cur_fin_ff, cur_fin_in;
   logic           second_ff, second_in;
   logic           use_older_ff, use_older_in;
   logic [W:0]     dx_raw_ff, dx_raw_in, dy_raw_ff, dy_raw_in;
   logic [W-1:0]   res_slope_ff, res_slope_in;
   reason_type     res_reason_ff, res_reason_in;
   logic           res_fin_ff, res_fin_in;
   logic           res_end_ff, res_end_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]   rsp_slope_ff, rsp_slope_in;
   reason_type     rsp_reason_ff, rsp_reason_in;
   logic           rsp_fin_ff, rsp_fin_in;
   logic           rsp_end_ff, rsp_end_in;

   logic           req_accept;
   logic           out_free;
   logic           more_needed;
   logic           x_equal;
   logic           extremum;
   logic           dx_zero;
   logic [W-1:0]   ax, ay;
   logic [W-1:0]   dx_mag, dy_mag;
   logic           div_start;
   logic [W-1:0]   div_slope;
   div_status_type div_status;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid & req_tready;
   assign out_free    = ~rsp_valid_ff | rsp_tready;
   assign more_needed = cur_fin_ff & ~second_ff & (held_ff != HELD_NONE);

   // Inner knot checks: coincident abscissas, then extremum or plateau
   assign x_equal  = (older_x_ff == newer_x_ff) || (newer_x_ff == cur_x_ff) ||
                     (older_x_ff == cur_x_ff);
   assign extremum = !(((signed'(older_y_ff) < signed'(newer_y_ff)) &&
                        (signed'(cur_y_ff)   > signed'(newer_y_ff))) ||
                       ((signed'(older_y_ff) > signed'(newer_y_ff)) &&
                        (signed'(cur_y_ff)   < signed'(newer_y_ff))));

   // Left end of the chord
   assign ax = use_older_ff ? older_x_ff : newer_x_ff;
   assign ay = use_older_ff ? older_y_ff : newer_y_ff;

   // Magnitudes and sign of the differences
   assign dx_zero   = (dx_raw_ff == '0);
   assign dx_mag    = dx_raw_ff[W] ? (~dx_raw_ff[W-1:0] + 1'b1) : dx_raw_ff[W-1:0];
   assign dy_mag    = dy_raw_ff[W] ? (~dy_raw_ff[W-1:0] + 1'b1) : dy_raw_ff[W-1:0];
   assign div_start = (state_ff == ST_ABS) && !dx_zero;

   skse_divider #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (dy_mag),
      .den    (dx_mag),
      .neg    (dy_raw_ff[W] ^ dx_raw_ff[W]),
      .slope  (div_slope),
      .status (div_status)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            unique case (held_ff)
               HELD_NONE: state_in = cur_fin_ff ? ST_EMIT : ST_IDLE;
               HELD_ONE:  state_in = ST_DIFF;
               HELD_TWO:  state_in = (x_equal || extremum) ? ST_EMIT : ST_DIFF;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_DIFF: state_in = ST_ABS;
         ST_ABS:  state_in = dx_zero ? ST_EMIT : ST_DIV;
         ST_DIV: begin
            if (div_status.done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               if (more_needed) begin
                  state_in = (held_ff == HELD_ONE) ? ST_EMIT : ST_DIFF;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and output register
   always_comb begin
      held_in       = held_ff;
      older_x_in    = older_x_ff;
      older_y_in    = older_y_ff;
      newer_x_in    = newer_x_ff;
      newer_y_in    = newer_y_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      cur_fin_in    = cur_fin_ff;
      second_in     = second_ff;
      use_older_in  = use_older_ff;
      dx_raw_in     = dx_raw_ff;
      dy_raw_in     = dy_raw_ff;
      res_slope_in  = res_slope_ff;
      res_reason_in = res_reason_ff;
      res_fin_in    = res_fin_ff;
      res_end_in    = res_end_ff;
      rsp_slope_in  = rsp_slope_ff;
      rsp_reason_in = rsp_reason_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // capture the incoming knot
            if (req_accept) begin
               cur_x_in   = req_tdata[W-1:0];
               cur_y_in   = req_tdata[2*W-1:W];
               cur_fin_in = req_tlast;
            end
         end
         ST_DECIDE: begin
            second_in  = 1'b0;
            res_fin_in = 1'b0;
            res_end_in = ~cur_fin_ff;
            unique case (held_ff)
               HELD_NONE: begin
                  if (cur_fin_ff) begin
                     res_slope_in  = '0;
                     res_reason_in = REASON_LONE;
                     res_fin_in    = 1'b1;
                     res_end_in    = 1'b1;
                  end else begin
                     newer_x_in = cur_x_ff;
                     newer_y_in = cur_y_ff;
                     held_in    = HELD_ONE;
                  end
               end
               HELD_ONE: use_older_in = 1'b0;
               HELD_TWO: begin
                  use_older_in = 1'b1;
                  if (x_equal) begin
                     res_slope_in  = '0;
                     res_reason_in = REASON_EQUAL_X;
                  end else if (extremum) begin
                     res_slope_in  = '0;
                     res_reason_in = REASON_EXTREMUM;
                  end
               end
               default: held_in = HELD_NONE;
            endcase
         end
         ST_DIFF: begin
            // differences of offset-binary coordinates, right minus left
            dx_raw_in = {2'b0, cur_x_ff[W-2:0]} + {1'b0, ~cur_x_ff[W-1], {(W-1){1'b0}}}
                      - ({2'b0, ax[W-2:0]} + {1'b0, ~ax[W-1], {(W-1){1'b0}}});
            dy_raw_in = {2'b0, cur_y_ff[W-2:0]} + {1'b0, ~cur_y_ff[W-1], {(W-1){1'b0}}}
                      - ({2'b0, ay[W-2:0]} + {1'b0, ~ay[W-1], {(W-1){1'b0}}});
         end
         ST_ABS: begin
            if (dx_zero) begin
               res_slope_in  = '0;
               res_reason_in = REASON_EQUAL_X;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               res_slope_in  = div_slope;
               res_reason_in = div_status.sat ? REASON_SATURATED : REASON_COMPUTED;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               // load the output word
               rsp_valid_in  = 1'b1;
               rsp_slope_in  = res_slope_ff;
               rsp_reason_in = res_reason_ff;
               rsp_fin_in    = res_fin_ff;
               rsp_end_in    = res_end_ff;
               if (more_needed) begin
                  // final knot's own slope: chord from the newer knot
                  second_in    = 1'b1;
                  res_fin_in   = 1'b1;
                  res_end_in   = 1'b1;
                  use_older_in = 1'b0;
               end else if (cur_fin_ff) begin
                  held_in = HELD_NONE;
               end else if (held_ff != HELD_NONE) begin
                  // advance the window
                  older_x_in = newer_x_ff;
                  older_y_in = newer_y_ff;
                  newer_x_in = cur_x_ff;
                  newer_y_in = cur_y_ff;
                  held_in    = HELD_TWO;
               end
            end
         end
         default: held_in = held_ff;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= HELD_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      older_x_ff    <= older_x_in;
      older_y_ff    <= older_y_in;
      newer_x_ff    <= newer_x_in;
      newer_y_ff    <= newer_y_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      cur_fin_ff    <= cur_fin_in;
      second_ff     <= second_in;
      use_older_ff  <= use_older_in;
      dx_raw_ff     <= dx_raw_in;
      dy_raw_ff     <= dy_raw_in;
      res_slope_ff  <= res_slope_in;
      res_reason_ff <= res_reason_in;
      res_fin_ff    <= res_fin_in;
      res_end_ff    <= res_end_in;
      rsp_slope_ff  <= rsp_slope_in;
      rsp_reason_ff <= rsp_reason_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OutDataW'(rsp_slope_ff);
   assign rsp_tuser  = {rsp_fin_ff, rsp_reason_ff};
   assign rsp_tlast  = rsp_end_ff;

   // An accepted knot is examined in the very next cycle
   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_DECIDE))
      else $error("accepted knot not examined next cycle");

   // A slope for the final knot always closes the run
   a_final_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fin_ff) |-> rsp_end_ff)
      else $error("final-knot slope without run end");

   // A lone knot reports a zero slope for the final knot
   a_lone_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_reason_ff == REASON_LONE)) |->
         ((rsp_slope_ff == '0) && rsp_fin_ff))
      else $error("lone knot with nonzero slope");

endmodule
